>>> sv/dtt_pkg.sv
// Package for the divider/counter timer block.
// Holds the item types, command and register offset codes, and group masks.
// No dependencies.
package dtt_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] tick_amount;
        logic [7:0] reg_offset;
        logic [7:0] write_data;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] irq_flags;
    } rsp_item_t;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [7:0] OFF_DIV     = 8'h04;
    localparam logic [7:0] OFF_COUNTER = 8'h05;
    localparam logic [7:0] OFF_RELOAD  = 8'h06;
    localparam logic [7:0] OFF_CONTROL = 8'h07;
    localparam logic [7:0] OFF_FLAGS   = 8'h0F;

    localparam int unsigned CTRL_ENABLE_BIT = 2;
    localparam logic [7:0] IRQ_TIMER  = 8'h04;
    localparam logic [7:0] FLAGS_HIGH = 8'hE0;
    localparam logic [7:0] UNMAPPED   = 8'hFF;

    localparam logic [9:0] GROUP_MASK [4] = '{10'd1023, 10'd15, 10'd63, 10'd255};

endpackage

>>> sv/dtt_in_reg.sv
// Input register stage of the timer block.
// Holds one accepted item until the execute step can pass it on.
// Depends on dtt_pkg.
module dtt_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  dtt_pkg::cmd_item_t cmd_item,
    input  logic              advance,
    output logic              fire,
    output dtt_pkg::cmd_item_t exec_item
);
    import dtt_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cmd_item_t item_reg;
    logic      accept;

    assign fire      = valid_reg && advance;
    assign cmd_stall = valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;
    assign exec_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_item;
        end
    end

endmodule

>>> sv/dtt_exec.sv
// Execute step of the timer block: timer state registers and the
// tick / read / write logic that updates them and forms the result.
// Depends on dtt_pkg.
module dtt_exec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  dtt_pkg::cmd_item_t item,
    output dtt_pkg::rsp_item_t rsp
);
    import dtt_pkg::*;

    logic [15:0] divider_reg, divider_next;
    logic [7:0]  counter_reg, counter_next;
    logic [7:0]  reload_reg, reload_next;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  flag_reg, flag_next;
    logic [7:0]  pending_reg, pending_next;

    always_comb
    begin
        logic [9:0]  mask;
        logic [10:0] grp_sum;
        logic [7:0]  cnt_inc;
        logic [7:0]  rd;

        divider_next = divider_reg;
        counter_next = counter_reg;
        reload_next  = reload_reg;
        control_next = control_reg;
        flag_next    = flag_reg;
        pending_next = pending_reg;
        rd           = 8'd0;
        mask         = GROUP_MASK[control_reg[1:0]];
        grp_sum      = {1'b0, divider_reg[9:0] & mask}
                     + {3'b000, item.tick_amount & mask[7:0]};
        cnt_inc      = counter_reg + 8'd1;

        case (item.command)
            CMD_TICK:
            begin
                flag_next    = flag_reg | pending_reg;
                pending_next = 8'd0;
                divider_next = divider_reg + {8'd0, item.tick_amount};
                if (control_reg[CTRL_ENABLE_BIT] && (grp_sum > {1'b0, mask}))
                begin
                    if (cnt_inc == 8'd0)
                    begin
                        counter_next = reload_reg;
                        pending_next = IRQ_TIMER;
                    end
                    else
                    begin
                        counter_next = cnt_inc;
                    end
                end
            end
            CMD_READ:
            begin
                case (item.reg_offset)
                    OFF_DIV:     rd = divider_reg[15:8];
                    OFF_COUNTER: rd = counter_reg;
                    OFF_RELOAD:  rd = reload_reg;
                    OFF_CONTROL: rd = control_reg;
                    OFF_FLAGS:   rd = flag_reg | FLAGS_HIGH;
                    default:     rd = UNMAPPED;
                endcase
            end
            CMD_WRITE:
            begin
                case (item.reg_offset)
                    OFF_DIV:     divider_next = 16'd0;
                    OFF_COUNTER: counter_next = item.write_data;
                    OFF_RELOAD:  reload_next  = item.write_data;
                    OFF_CONTROL: control_next = item.write_data;
                    OFF_FLAGS:   flag_next    = item.write_data;
                    default:     ;
                endcase
            end
            default: ;
        endcase

        rsp.read_data = rd;
        rsp.irq_flags = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg <= 16'd0;
            counter_reg <= 8'd0;
            reload_reg  <= 8'd0;
            control_reg <= 8'd0;
            flag_reg    <= 8'd0;
            pending_reg <= 8'd0;
        end
        else if (fire)
        begin
            divider_reg <= divider_next;
            counter_reg <= counter_next;
            reload_reg  <= reload_next;
            control_reg <= control_next;
            flag_reg    <= flag_next;
            pending_reg <= pending_next;
        end
    end

endmodule

>>> sv/dtt_out_reg.sv
// Result register stage of the timer block.
// Holds a finished item until the receiver takes it.
// Depends on dtt_pkg.
module dtt_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  dtt_pkg::rsp_item_t rsp_in,
    output logic               advance,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dtt_pkg::rsp_item_t rsp_item
);
    import dtt_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    rsp_item_t item_reg;

    assign advance   = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            item_reg <= rsp_in;
        end
    end

endmodule

>>> sv/divider_tima_timer.sv
// Divider/counter timer with interrupt flag register.
// Command channel (cmd_*) takes tick, register read and register write items;
// response channel (rsp_*) returns one item per command: read_data and the
// flag register after the command.
// An item is moved when valid is high and stall is low at a rising edge.
// An accepted command is held in the input register, executed once the
// response register can take its result, and then held there until taken.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single execute step that reads and updates the timer registers.
// When the receiver stalls, the response register holds its item and the
// input register still takes one more command; cmd_stall rises once both
// are full.
// Reset (rst_n low, asynchronous) clears divider, counter, reload, control,
// flag and pending registers and empties both stages.
// Depends on dtt_pkg, dtt_in_reg, dtt_exec, dtt_out_reg.
module divider_tima_timer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  dtt_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dtt_pkg::rsp_item_t rsp_item
);
    import dtt_pkg::*;

    logic      advance;
    logic      fire;
    cmd_item_t exec_item;
    rsp_item_t exec_rsp;

    dtt_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .advance   (advance),
        .fire      (fire),
        .exec_item (exec_item)
    );

    dtt_exec u_exec (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (exec_item),
        .rsp   (exec_rsp)
    );

    dtt_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rsp_in    (exec_rsp),
        .advance   (advance),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for divider_tima_timer: a directed table, then random ticks, reads and writes,
// with each response checked against its table row or a timer predictor kept in this file.
// Depends on dtt_pkg and the divider_tima_timer RTL.
module testbench;
    import dtt_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int DIR_ROWS = 26;
    localparam int RAND_ITEMS = 1874;
    localparam int QUIET_FROM = 900;
    localparam int QUIET_TO = 1200;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        cmd_item_t item;
        logic      typed;
        rsp_item_t want;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd_item = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    logic      quiet = 1'b0;

    logic [15:0] tmr_div = '0;
    logic [7:0]  tmr_cnt = '0;
    logic [7:0]  tmr_reload = '0;
    logic [7:0]  tmr_ctrl = '0;
    logic [7:0]  tmr_flags = '0;
    logic [7:0]  tmr_pend = '0;

    rsp_item_t due_rsp_q[$];
    int        mismatches = 0;
    dir_row_t  dir_tab [DIR_ROWS];

    divider_tima_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Applies one item to the timer state and returns the response it gives.
    function automatic rsp_item_t timer_apply(input cmd_item_t it);
        rsp_item_t   r;
        logic [15:0] old;
        logic [9:0]  mask;
        logic [10:0] sum;
        r = '0;
        mask = '0;
        case (it.command)
            CMD_TICK:
            begin
                old = tmr_div;
                tmr_flags = tmr_flags | tmr_pend;
                tmr_pend = '0;
                tmr_div = tmr_div + {8'd0, it.tick_amount};
                if (tmr_ctrl[CTRL_ENABLE_BIT])
                begin
                    case (tmr_ctrl[1:0])
                        2'd0: mask = 10'd1023;
                        2'd1: mask = 10'd15;
                        2'd2: mask = 10'd63;
                        default: mask = 10'd255;
                    endcase
                    sum = {1'b0, old[9:0] & mask} + {3'b000, it.tick_amount & mask[7:0]};
                    if (sum > {1'b0, mask})
                    begin
                        tmr_cnt = tmr_cnt + 8'd1;
                        if (tmr_cnt == 8'd0)
                        begin
                            tmr_cnt = tmr_reload;
                            tmr_pend = tmr_pend | IRQ_TIMER;
                        end
                    end
                end
            end
            CMD_READ:
            begin
                case (it.reg_offset)
                    OFF_DIV:     r.read_data = tmr_div[15:8];
                    OFF_COUNTER: r.read_data = tmr_cnt;
                    OFF_RELOAD:  r.read_data = tmr_reload;
                    OFF_CONTROL: r.read_data = tmr_ctrl;
                    OFF_FLAGS:   r.read_data = tmr_flags | FLAGS_HIGH;
                    default:     r.read_data = UNMAPPED;
                endcase
            end
            CMD_WRITE:
            begin
                case (it.reg_offset)
                    OFF_DIV:     tmr_div = '0;
                    OFF_COUNTER: tmr_cnt = it.write_data;
                    OFF_RELOAD:  tmr_reload = it.write_data;
                    OFF_CONTROL: tmr_ctrl = it.write_data;
                    OFF_FLAGS:   tmr_flags = it.write_data;
                    default:     ;
                endcase
            end
            default: ;
        endcase
        r.irq_flags = tmr_flags;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] c, input logic [7:0] a,
                                        input logic [7:0] o, input logic [7:0] d,
                                        input logic t, input logic [7:0] rd,
                                        input logic [7:0] irq);
        dir_row_t row;
        row.item.command = c;
        row.item.tick_amount = a;
        row.item.reg_offset = o;
        row.item.write_data = d;
        row.typed = t;
        row.want.read_data = rd;
        row.want.irq_flags = irq;
        return row;
    endfunction

    task automatic send_item(input cmd_item_t it, input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 21)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
        rsp_stall <= !quiet && ($urandom_range(0, 99) < 21);

    always @(posedge clk)
    begin : rsp_check
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_rsp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected item: read_data %h irq_flags %h",
                             rsp_item.read_data, rsp_item.irq_flags);
            end
            else
            begin
                want = due_rsp_q.pop_front();
                if (rsp_item.read_data !== want.read_data
                    || rsp_item.irq_flags !== want.irq_flags)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("bad item: read_data %h (exp %h) irq_flags %h (exp %h)",
                                 rsp_item.read_data, want.read_data,
                                 rsp_item.irq_flags, want.irq_flags);
                end
            end
        end
    end

    initial
    begin : stimulus
        cmd_item_t it;
        rsp_item_t w;
        int        idx;
        int        counted;
        int        pick;
        int        sel;
        bit        window;

        dir_tab[0]  = mk_row(CMD_READ,  8'h00, OFF_DIV,     8'h00, 1'b1, 8'h00, 8'h00);
        dir_tab[1]  = mk_row(CMD_READ,  8'h00, OFF_FLAGS,   8'h00, 1'b1, 8'hE0, 8'h00);
        dir_tab[2]  = mk_row(CMD_READ,  8'h00, 8'h00,       8'h00, 1'b1, 8'hFF, 8'h00);
        dir_tab[3]  = mk_row(CMD_READ,  8'hFF, 8'hFF,       8'hFF, 1'b1, 8'hFF, 8'h00);
        dir_tab[4]  = mk_row(CMD_NONE,  8'hFF, 8'hFF,       8'hFF, 1'b1, 8'h00, 8'h00);
        // timer disabled: divider still advances
        dir_tab[5]  = mk_row(CMD_TICK,  8'hFF, 8'h00,       8'h00, 1'b1, 8'h00, 8'h00);
        dir_tab[6]  = mk_row(CMD_TICK,  8'hFF, 8'h00,       8'h00, 1'b1, 8'h00, 8'h00);
        dir_tab[7]  = mk_row(CMD_READ,  8'h00, OFF_DIV,     8'h00, 1'b1, 8'h01, 8'h00);
        dir_tab[8]  = mk_row(CMD_WRITE, 8'h00, OFF_DIV,     8'hFF, 1'b1, 8'h00, 8'h00);
        dir_tab[9]  = mk_row(CMD_READ,  8'h00, OFF_DIV,     8'h00, 1'b1, 8'h00, 8'h00);
        dir_tab[10] = mk_row(CMD_WRITE, 8'h00, OFF_RELOAD,  8'hA5, 1'b1, 8'h00, 8'h00);
        dir_tab[11] = mk_row(CMD_WRITE, 8'h00, OFF_COUNTER, 8'hFF, 1'b1, 8'h00, 8'h00);
        dir_tab[12] = mk_row(CMD_WRITE, 8'h00, OFF_CONTROL, 8'h05, 1'b1, 8'h00, 8'h00);
        // counter wraps on the second tick, flag shows on the third
        dir_tab[13] = mk_row(CMD_TICK,  8'h0F, 8'h00,       8'h00, 1'b0, 8'h00, 8'h00);
        dir_tab[14] = mk_row(CMD_TICK,  8'h01, 8'h00,       8'h00, 1'b0, 8'h00, 8'h00);
        dir_tab[15] = mk_row(CMD_TICK,  8'h00, 8'h00,       8'h00, 1'b1, 8'h00, 8'h04);
        dir_tab[16] = mk_row(CMD_READ,  8'h00, OFF_COUNTER, 8'h00, 1'b1, 8'hA5, 8'h04);
        dir_tab[17] = mk_row(CMD_READ,  8'h00, OFF_FLAGS,   8'h00, 1'b1, 8'hE4, 8'h04);
        dir_tab[18] = mk_row(CMD_WRITE, 8'h00, OFF_FLAGS,   8'h00, 1'b1, 8'h00, 8'h00);
        dir_tab[19] = mk_row(CMD_WRITE, 8'h00, 8'h80,       8'hFF, 1'b1, 8'h00, 8'h00);
        dir_tab[20] = mk_row(CMD_READ,  8'h00, OFF_RELOAD,  8'h00, 1'b1, 8'hA5, 8'h00);
        dir_tab[21] = mk_row(CMD_READ,  8'h00, OFF_CONTROL, 8'h00, 1'b1, 8'h05, 8'h00);
        dir_tab[22] = mk_row(CMD_WRITE, 8'h00, OFF_CONTROL, 8'hFF, 1'b0, 8'h00, 8'h00);
        dir_tab[23] = mk_row(CMD_TICK,  8'hFF, 8'h00,       8'h00, 1'b0, 8'h00, 8'h00);
        dir_tab[24] = mk_row(CMD_WRITE, 8'h00, OFF_FLAGS,   8'hFF, 1'b1, 8'h00, 8'hFF);
        dir_tab[25] = mk_row(CMD_READ,  8'h00, OFF_FLAGS,   8'h00, 1'b1, 8'hFF, 8'hFF);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < DIR_ROWS; idx++)
        begin
            send_item(dir_tab[idx].item, 1'b1);
            w = timer_apply(dir_tab[idx].item);
            due_rsp_q.push_back(dir_tab[idx].typed ? dir_tab[idx].want : w);
        end

        counted = 0;
        while (counted < RAND_ITEMS)
        begin
            window = (counted >= QUIET_FROM && counted < QUIET_TO);
            quiet <= window;
            it.tick_amount = 8'($urandom_range(0, 255));
            it.reg_offset = 8'($urandom_range(0, 255));
            it.write_data = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                it.command = CMD_TICK;
                if ($urandom_range(0, 9) == 0)
                    it.tick_amount = 8'hFF;
            end
            else if (pick < 72)
            begin
                it.command = CMD_READ;
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 4))
                        0: it.reg_offset = OFF_DIV;
                        1: it.reg_offset = OFF_COUNTER;
                        2: it.reg_offset = OFF_RELOAD;
                        3: it.reg_offset = OFF_CONTROL;
                        default: it.reg_offset = OFF_FLAGS;
                    endcase
                end
            end
            else if (pick < 96)
            begin
                it.command = CMD_WRITE;
                sel = $urandom_range(0, 19);
                if (sel < 7)
                begin
                    it.reg_offset = OFF_CONTROL;
                    if (sel < 6)
                        it.write_data[CTRL_ENABLE_BIT] = 1'b1;
                end
                else if (sel < 11)
                begin
                    // near the top so the counter wraps often
                    it.reg_offset = OFF_COUNTER;
                    if (sel < 10)
                        it.write_data[7:3] = 5'h1F;
                end
                else if (sel < 14)
                begin
                    it.reg_offset = OFF_RELOAD;
                    if (sel < 13)
                        it.write_data[7:4] = 4'hF;
                end
                else if (sel < 16)
                    it.reg_offset = OFF_FLAGS;
                else if (sel < 17)
                    it.reg_offset = OFF_DIV;
            end
            else
                it.command = CMD_NONE;

            counted++;

            send_item(it, !window);
            due_rsp_q.push_back(timer_apply(it));
        end

        cmd_valid <= 1'b0;
        quiet <= 1'b0;
        while (due_rsp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
